// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define REC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define REC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define REC_ASSERT_IMPL(label, clk, rstn, ante, cons)

`define REC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/rec_pkg.sv -----
// shared types, constants and the quadrature step table
package rec_pkg;

    localparam int HOLD_COUNTER_BITS_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ELAPSED_W = 8;
    localparam int EVENT_W   = 3;
    localparam int DETENT_W  = 16;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_HOLD = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST       = 16'd25;
    localparam logic [CFG_W-1:0] LONG_HOLD_RST      = 16'd2000;
    localparam logic [CFG_W-1:0] VERY_LONG_HOLD_RST = 16'd5000;

    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_CW       = 3'd1;
    localparam logic [EVENT_W-1:0] EV_CCW      = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SHORT    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TWO_SEC  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_FIVE_SEC = 3'd5;

    localparam logic [DETENT_W-1:0] DETENT_CW  = 16'h0004;
    localparam logic [DETENT_W-1:0] DETENT_CCW = 16'hFFFC;

    typedef struct packed {
        logic down;
        logic long_fired;
        logic very_long_fired;
    } btn_status_t;

    function automatic logic [DETENT_W-1:0] step_value(input logic [3:0] idx);
        logic [DETENT_W-1:0] v;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  v = 16'hFFFF;
            4'd2, 4'd4, 4'd11, 4'd13: v = 16'h0001;
            4'd3, 4'd6, 4'd9, 4'd12:  v = 16'h000E;
            default:                  v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/rec_rotary.sv -----
// quadrature transition decoder with detent accumulator
module rec_rotary (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic                         pin_a,
    input  logic                         pin_b,
    output logic [rec_pkg::EVENT_W-1:0]  rot_event
);

    logic [1:0]                    last_pair_reg;
    logic [1:0]                    last_pair_next;
    logic [rec_pkg::DETENT_W-1:0]  detent_sum_reg;
    logic [rec_pkg::DETENT_W-1:0]  detent_sum_next;
    logic [rec_pkg::DETENT_W-1:0]  detent_add;

    always_comb begin
        last_pair_next  = {pin_a, pin_b};
        detent_add      = detent_sum_reg + rec_pkg::step_value({last_pair_reg, pin_a, pin_b});
        detent_sum_next = detent_add;
        rot_event       = rec_pkg::EV_NONE;
        if (detent_add[1:0] == 2'b00) begin
            detent_sum_next = '0;
            if (detent_add == rec_pkg::DETENT_CW) begin
                rot_event = rec_pkg::EV_CW;
            end else if (detent_add == rec_pkg::DETENT_CCW) begin
                rot_event = rec_pkg::EV_CCW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pair_reg  <= '0;
            detent_sum_reg <= '0;
        end else if (step_en) begin
            last_pair_reg  <= last_pair_next;
            detent_sum_reg <= detent_sum_next;
        end
    end

endmodule

// ----- rtl/rec_button.sv -----
// push-button press classifier with saturating hold timer
module rec_button #(
    parameter int HOLD_COUNTER_BITS = rec_pkg::HOLD_COUNTER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  logic                           button_level,
    input  logic [rec_pkg::ELAPSED_W-1:0]  elapsed_ms,
    input  logic [rec_pkg::CFG_W-1:0]      debounce_ms,
    input  logic [rec_pkg::CFG_W-1:0]      long_hold_ms,
    input  logic [rec_pkg::CFG_W-1:0]      very_long_hold_ms,
    output logic [rec_pkg::EVENT_W-1:0]    btn_event,
    output rec_pkg::btn_status_t           status
);

    localparam int CMP_W = (HOLD_COUNTER_BITS > rec_pkg::CFG_W) ?
                           HOLD_COUNTER_BITS : rec_pkg::CFG_W;

    logic [HOLD_COUNTER_BITS-1:0] held_reg;
    logic [HOLD_COUNTER_BITS-1:0] held_next;
    logic [HOLD_COUNTER_BITS:0]   held_sum;
    logic [HOLD_COUNTER_BITS-1:0] held_upd;
    logic [CMP_W-1:0]             held_x;
    logic                         down_reg;
    logic                         down_next;
    logic                         long_reg;
    logic                         long_next;
    logic                         vlong_reg;
    logic                         vlong_next;

    always_comb begin
        held_sum   = {1'b0, held_reg} + (HOLD_COUNTER_BITS + 1)'(elapsed_ms);
        held_upd   = held_reg;
        if (down_reg) begin
            held_upd = held_sum[HOLD_COUNTER_BITS] ? '1 : held_sum[HOLD_COUNTER_BITS-1:0];
        end
        held_x     = CMP_W'(held_upd);
        held_next  = held_upd;
        down_next  = down_reg;
        long_next  = long_reg;
        vlong_next = vlong_reg;
        btn_event  = rec_pkg::EV_NONE;
        if (!button_level && !down_reg) begin
            held_next = '0;
            down_next = 1'b1;
        end else if (button_level && down_reg) begin
            down_next = 1'b0;
            if (long_reg) begin
                long_next = 1'b0;
            end else if (vlong_reg) begin
                vlong_next = 1'b0;
            end else if (held_x > CMP_W'(debounce_ms)) begin
                btn_event = rec_pkg::EV_SHORT;
            end
        end else if (down_reg && held_x > CMP_W'(long_hold_ms)) begin
            if (!long_reg && !vlong_reg) begin
                long_next = 1'b1;
                btn_event = rec_pkg::EV_TWO_SEC;
            end else if (held_x > CMP_W'(very_long_hold_ms) && !vlong_reg) begin
                long_next  = 1'b0;
                vlong_next = 1'b1;
                btn_event  = rec_pkg::EV_FIVE_SEC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            down_reg  <= 1'b0;
            long_reg  <= 1'b0;
            vlong_reg <= 1'b0;
        end else if (step_en) begin
            held_reg  <= held_next;
            down_reg  <= down_next;
            long_reg  <= long_next;
            vlong_reg <= vlong_next;
        end
    end

    assign status.down            = down_reg;
    assign status.long_fired      = long_reg;
    assign status.very_long_fired = vlong_reg;

endmodule

// ----- rtl/rotary_encoder_with_press_classifier.sv -----
// top level: rotary encoder decoder with push-button press classifier
//
// s_ channel: one item per sample of the encoder pins, the button level
// (0 pressed), the milliseconds since the previous sample and a take flag.
// m_ channel: exactly one item per input item, carrying the sticky event
// code after that sample (0 none, 1 cw, 2 ccw, 3 short, 4 two-second,
// 5 five-second). A set take flag clears the event after it is reported.
// cfg channel: writes debounce_ms (0), long_hold_ms (1) and
// very_long_hold_ms (2); other indexes are ignored. Always ready; write
// only while no item is in flight.
// The output register takes the result at the same edge that accepts the
// item. Throughput is one item per cycle while the receiver is ready,
// as the state update feeds the output register directly.
// The input is ready whenever the output register is empty or being taken,
// so a stalled receiver holds the result and stops input after one item.
// Synchronous reset clears all state but the held output code, empties the
// output register and restores the register defaults (25, 2000, 5000).
`include "assert_macros.svh"

module rotary_encoder_with_press_classifier #(
    parameter int HOLD_COUNTER_BITS = rec_pkg::HOLD_COUNTER_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pin_a, pin_b, button_level, elapsed_ms[7:0], take_event, zero pad
    input  logic [rec_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // event_code[2:0], zero pad
    output logic [rec_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rec_pkg::CFG_W-1:0]        cfg_data
);

    logic                           in_acc;
    logic                           pin_a;
    logic                           pin_b;
    logic                           button_level;
    logic [rec_pkg::ELAPSED_W-1:0]  elapsed_ms;
    logic                           take_event;

    logic [rec_pkg::CFG_W-1:0]      debounce_reg;
    logic [rec_pkg::CFG_W-1:0]      long_hold_reg;
    logic [rec_pkg::CFG_W-1:0]      very_long_hold_reg;

    logic [rec_pkg::EVENT_W-1:0]    btn_event;
    logic [rec_pkg::EVENT_W-1:0]    rot_event;
    rec_pkg::btn_status_t           btn_status;

    logic [rec_pkg::EVENT_W-1:0]    pending_reg;
    logic [rec_pkg::EVENT_W-1:0]    pending_next;
    logic [rec_pkg::EVENT_W-1:0]    report;
    logic [rec_pkg::EVENT_W-1:0]    out_code_reg;
    logic                           out_valid_reg;

    assign pin_a        = s_tdata[0];
    assign pin_b        = s_tdata[1];
    assign button_level = s_tdata[2];
    assign elapsed_ms   = s_tdata[10:3];
    assign take_event   = s_tdata[11];

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg       <= rec_pkg::DEBOUNCE_RST;
            long_hold_reg      <= rec_pkg::LONG_HOLD_RST;
            very_long_hold_reg <= rec_pkg::VERY_LONG_HOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rec_pkg::REG_DEBOUNCE:       debounce_reg       <= cfg_data;
                rec_pkg::REG_LONG_HOLD:      long_hold_reg      <= cfg_data;
                rec_pkg::REG_VERY_LONG_HOLD: very_long_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rec_button #(
        .HOLD_COUNTER_BITS (HOLD_COUNTER_BITS)
    ) u_button (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step_en           (in_acc),
        .button_level      (button_level),
        .elapsed_ms        (elapsed_ms),
        .debounce_ms       (debounce_reg),
        .long_hold_ms      (long_hold_reg),
        .very_long_hold_ms (very_long_hold_reg),
        .btn_event         (btn_event),
        .status            (btn_status)
    );

    rec_rotary u_rotary (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (in_acc),
        .pin_a     (pin_a),
        .pin_b     (pin_b),
        .rot_event (rot_event)
    );

    // button events win over rotation
    always_comb begin
        report = pending_reg;
        if (btn_event != rec_pkg::EV_NONE) begin
            report = btn_event;
        end else if (rot_event != rec_pkg::EV_NONE) begin
            report = rot_event;
        end
        pending_next = take_event ? rec_pkg::EV_NONE : report;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= rec_pkg::EV_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                pending_reg   <= pending_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_code_reg <= report;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rec_pkg::M_TDATA_W - rec_pkg::EVENT_W){1'b0}}, out_code_reg};

    `REC_ASSERT_NEXT(a_take_clears, aclk, aresetn, in_acc && take_event, pending_reg == rec_pkg::EV_NONE)
    `REC_ASSERT_NEXT(a_item_gives_result, aclk, aresetn, in_acc, m_tvalid)
    `REC_ASSERT_IMPL(a_flags_exclusive, aclk, aresetn, btn_status.long_fired, !btn_status.very_long_fired)
    `REC_ASSERT_IMPL(a_flags_need_press, aclk, aresetn, btn_status.long_fired || btn_status.very_long_fired, btn_status.down)
    `REC_ASSERT_IMPL(a_code_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= rec_pkg::EV_FIVE_SEC)

endmodule

// ----- tb/tb_rotary_encoder_with_press_classifier.sv -----
// testbench for the rotary encoder decoder with push-button press classifier
`timescale 1ns / 100ps

module tb_rotary_encoder_with_press_classifier;

    localparam int HOLD_W = rec_pkg::HOLD_COUNTER_BITS_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int STALL_CYCLES = 200;
    localparam logic [rec_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int STEP_DELTA [16] = '{0, -1, 1, 14, 1, 0, 14, -1, -1, 14, 0, 1, 14, 1, -1, 0};
    localparam logic [1:0] ENC_GRAY [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

    typedef struct packed {
        logic       take;
        logic [7:0] elapsed;
        logic       level;
        logic       pin_b;
        logic       pin_a;
    } sample_t;

    typedef struct packed {
        logic       a;
        logic       b;
        logic       lvl;
        logic [7:0] el;
        logic       take;
        logic       known;
        logic [2:0] code;
    } dir_row_t;

    typedef struct {
        bit         known;
        logic [2:0] code;
    } tag_t;

    // a, b, level, elapsed, take, typed, event
    localparam dir_row_t DIR_TAB [25] = '{
        '{1'b0, 1'b0, 1'b1, 8'd0,   1'b0, 1'b1, rec_pkg::EV_NONE},
        '{1'b1, 1'b0, 1'b1, 8'd0,   1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b1, 1'b1, 1'b1, 8'd0,   1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b1, 1'b1, 8'd0,   1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b1, 8'd0,   1'b1, 1'b1, rec_pkg::EV_CW},
        '{1'b0, 1'b1, 1'b1, 8'd0,   1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b1, 1'b1, 1'b1, 8'd0,   1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b1, 1'b0, 1'b1, 8'd0,   1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b1, 8'd255, 1'b1, 1'b1, rec_pkg::EV_CCW},
        '{1'b1, 1'b1, 1'b1, 8'd0,   1'b1, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b1, 8'd0,   1'b1, 1'b0, rec_pkg::EV_NONE},
        '{1'b1, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b1, 1'b1, 1'b0, 8'd26,  1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b1, 8'd0,   1'b1, 1'b1, rec_pkg::EV_SHORT},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0, 1'b0, rec_pkg::EV_NONE},
        '{1'b0, 1'b0, 1'b0, 8'd255, 1'b1, 1'b1, rec_pkg::EV_TWO_SEC},
        '{1'b0, 1'b0, 1'b1, 8'd0,   1'b1, 1'b1, rec_pkg::EV_NONE}
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rec_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rec_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rec_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rec_pkg::CFG_W-1:0]      cfg_data;

    // predictor state
    logic [rec_pkg::CFG_W-1:0]    deb_ms   = rec_pkg::DEBOUNCE_RST;
    logic [rec_pkg::CFG_W-1:0]    long_ms  = rec_pkg::LONG_HOLD_RST;
    logic [rec_pkg::CFG_W-1:0]    vlong_ms = rec_pkg::VERY_LONG_HOLD_RST;
    logic [1:0]                   prev_pair = '0;
    logic [rec_pkg::DETENT_W-1:0] detent_acc = '0;
    logic [HOLD_W-1:0]            held_ms = '0;
    logic                         btn_down = 1'b0;
    logic                         two_sec_done = 1'b0;
    logic                         five_sec_done = 1'b0;
    logic [rec_pkg::EVENT_W-1:0]  event_reg = rec_pkg::EV_NONE;

    logic [rec_pkg::EVENT_W-1:0] event_fifo [$];
    tag_t                        typed_q [$];
    int                          fault_cnt = 0;
    int                          quiet_cycles = 0;
    bit                          idle_en = 1'b1;
    int                          hold_off_cycles = 0;

    // stimulus generator state
    int   enc_pos = 0;
    int   enc_dir = 1;
    logic btn_lvl = 1'b1;
    int   btn_left = 0;

    rotary_encoder_with_press_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic [rec_pkg::EVENT_W-1:0] classify_sample(input sample_t smp);
        logic [rec_pkg::EVENT_W-1:0] bev;
        logic [rec_pkg::EVENT_W-1:0] rev;
        logic [1:0]                  pair;
        logic [3:0]                  idx;
        logic [HOLD_W:0]             wide;
        bev = rec_pkg::EV_NONE;
        rev = rec_pkg::EV_NONE;
        if (btn_down) begin
            wide = {1'b0, held_ms} + (HOLD_W + 1)'(smp.elapsed);
            held_ms = wide[HOLD_W] ? '1 : wide[HOLD_W-1:0];
        end
        if (!smp.level && !btn_down) begin
            held_ms = '0;
            btn_down = 1'b1;
        end else if (smp.level && btn_down) begin
            btn_down = 1'b0;
            if (two_sec_done)
                two_sec_done = 1'b0;
            else if (five_sec_done)
                five_sec_done = 1'b0;
            else if (held_ms > deb_ms)
                bev = rec_pkg::EV_SHORT;
        end else if (btn_down && held_ms > long_ms) begin
            if (!two_sec_done && !five_sec_done) begin
                two_sec_done = 1'b1;
                bev = rec_pkg::EV_TWO_SEC;
            end else if (held_ms > vlong_ms && !five_sec_done) begin
                two_sec_done = 1'b0;
                five_sec_done = 1'b1;
                bev = rec_pkg::EV_FIVE_SEC;
            end
        end
        pair = {smp.pin_a, smp.pin_b};
        idx = {prev_pair, pair};
        prev_pair = pair;
        detent_acc = detent_acc + 16'(STEP_DELTA[idx]);
        if (detent_acc[1:0] == 2'b00) begin
            if (detent_acc == rec_pkg::DETENT_CW)
                rev = rec_pkg::EV_CW;
            else if (detent_acc == rec_pkg::DETENT_CCW)
                rev = rec_pkg::EV_CCW;
            detent_acc = '0;
        end
        if (bev != rec_pkg::EV_NONE)
            event_reg = bev;
        else if (rev != rec_pkg::EV_NONE)
            event_reg = rev;
        classify_sample = event_reg;
        if (smp.take)
            event_reg = rec_pkg::EV_NONE;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // scoreboard and watchdog
    always @(posedge aclk) begin
        logic [rec_pkg::EVENT_W-1:0] want;
        tag_t                        tag;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (event_fifo.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("unexpected result: event %0d",
                                 m_tdata[rec_pkg::EVENT_W-1:0]);
                end else begin
                    want = event_fifo.pop_front();
                    if (m_tdata[rec_pkg::EVENT_W-1:0] !== want) begin
                        fault_cnt++;
                        if (fault_cnt <= 10)
                            $display("event mismatch: expected %0d, got %0d",
                                     want, m_tdata[rec_pkg::EVENT_W-1:0]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                tag = typed_q.pop_front();
                want = classify_sample(s_tdata[11:0]);
                if (tag.known)
                    want = tag.code;
                event_fifo.push_back(want);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_rotary_encoder_with_press_classifier NOT OK");
                $finish;
            end
        end
    end

    task automatic push_item(input sample_t smp, input bit known, input logic [2:0] code);
        tag_t tag;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        tag.known = known;
        tag.code = code;
        typed_q.push_back(tag);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, smp};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (event_fifo.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rec_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rec_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rec_pkg::REG_DEBOUNCE:       deb_ms = val;
            rec_pkg::REG_LONG_HOLD:      long_ms = val;
            rec_pkg::REG_VERY_LONG_HOLD: vlong_ms = val;
            default: ;
        endcase
    endtask

    task automatic apply_thresholds(input logic [rec_pkg::CFG_W-1:0] deb,
                                    input logic [rec_pkg::CFG_W-1:0] lng,
                                    input logic [rec_pkg::CFG_W-1:0] vlng,
                                    input bit poke_unused);
        drain();
        write_reg(rec_pkg::REG_DEBOUNCE, deb);
        write_reg(rec_pkg::REG_LONG_HOLD, lng);
        write_reg(rec_pkg::REG_VERY_LONG_HOLD, vlng);
        if (poke_unused)
            write_reg(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n, input bit long_hold);
        sample_t smp;
        int      r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                enc_dir = -enc_dir;
            if (r < 75)
                enc_pos = (enc_pos + enc_dir) & 3;
            else if (r >= 88)
                enc_pos = $urandom_range(0, 3);
            {smp.pin_a, smp.pin_b} = ENC_GRAY[enc_pos];
            if (long_hold) begin
                btn_lvl = 1'b0;
                btn_left = 1;
            end else begin
                if (btn_left == 0) begin
                    btn_lvl = ~btn_lvl;
                    btn_left = btn_lvl ? $urandom_range(1, 12) : $urandom_range(1, 40);
                end
                btn_left--;
            end
            smp.level = btn_lvl;
            r = $urandom_range(0, 9);
            if (long_hold)
                smp.elapsed = (r == 0) ? 8'($urandom_range(0, 255)) : 8'd255;
            else if (r < 5)
                smp.elapsed = 8'($urandom_range(0, 30));
            else if (r < 9)
                smp.elapsed = 8'($urandom_range(0, 255));
            else
                smp.elapsed = 8'd255;
            smp.take = 1'($urandom_range(0, 1));
            push_item(smp, 1'b0, rec_pkg::EV_NONE);
        end
    endtask

    initial begin
        sample_t smp;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < 25; k++) begin
            smp.pin_a = DIR_TAB[k].a;
            smp.pin_b = DIR_TAB[k].b;
            smp.level = DIR_TAB[k].lvl;
            smp.elapsed = DIR_TAB[k].el;
            smp.take = DIR_TAB[k].take;
            push_item(smp, DIR_TAB[k].known, DIR_TAB[k].code);
        end

        // reset thresholds, with a long receiver stall in the middle
        run_random(60, 1'b0);
        hold_off_cycles = STALL_CYCLES;
        run_random(90, 1'b0);

        apply_thresholds(16'd10, 16'd300, 16'd700, 1'b0);
        run_random(200, 1'b0);

        apply_thresholds(16'd0, 16'd0, 16'd0, 1'b0);
        run_random(120, 1'b0);

        // held time saturates, nothing can exceed the thresholds
        apply_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_random(300, 1'b1);
        run_random(40, 1'b0);

        // saturated held time just passes the two-second threshold
        apply_thresholds(16'hFFFE, 16'hFFFE, 16'hFFFF, 1'b0);
        run_random(300, 1'b1);
        run_random(30, 1'b0);

        // two-second threshold above the five-second one
        apply_thresholds(16'd5, 16'd800, 16'd200, 1'b1);
        run_random(50, 1'b0);
        drain();
        run_random(50, 1'b0);

        apply_thresholds(rec_pkg::DEBOUNCE_RST, rec_pkg::LONG_HOLD_RST,
                         rec_pkg::VERY_LONG_HOLD_RST, 1'b0);
        idle_en = 1'b0;
        run_random(80, 1'b0);

        drain();
        if (fault_cnt == 0)
            $display("tb_rotary_encoder_with_press_classifier OK");
        else
            $display("tb_rotary_encoder_with_press_classifier NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rec_pkg.sv
rtl/rec_rotary.sv
rtl/rec_button.sv
rtl/rotary_encoder_with_press_classifier.sv
tb/tb_rotary_encoder_with_press_classifier.sv
